// ----- rtl/mto_pkg.sv -----
// shared types and constants of the morphing triangle/saw oscillator
package mto_pkg;

    localparam int PHASE_BITS = 32;
    localparam int OUT_BITS   = 16;
    localparam int FRAC_BITS  = 16;
    localparam int SHAPE_W    = FRAC_BITS + 1;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SHAPE_W-1:0] SHAPE_ONE = SHAPE_W'(1) << FRAC_BITS;

    // u = num * 2^OUT_BITS / den, one quotient bit per step
    localparam int DIV_STEPS = OUT_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    localparam logic [OUT_BITS-1:0] SAMPLE_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};

    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE  = 2'd2;

    typedef struct packed {
        logic [SHAPE_W-1:0] num;
        logic [SHAPE_W-1:0] den;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

// ----- rtl/mto_front.sv -----
// request front end: config registers, phase accumulator, segment selection
module mto_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mto_pkg::REQ_W-1:0]           i_req_type,
    input  logic [mto_pkg::PHASE_BITS-1:0]      i_new_phase,
    input  logic                                i_cfg_valid,
    input  logic [mto_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mto_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_push,
    output mto_pkg::t_job                       o_job,
    input  logic                                i_full
);

    logic [mto_pkg::PHASE_BITS-1:0] r_step;
    logic [mto_pkg::PHASE_BITS-1:0] r_offset;
    logic [mto_pkg::SHAPE_W-1:0]    r_shape;
    logic [mto_pkg::PHASE_BITS-1:0] r_phase;
    logic                           r_pend;

    logic                           w_accept;
    logic [mto_pkg::PHASE_BITS-1:0] w_sampled;
    logic [mto_pkg::SHAPE_W-1:0]    w_p;
    logic [mto_pkg::SHAPE_W-1:0]    w_s;

    assign o_in_ready = !r_pend;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = r_pend && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_offset <= '0;
            r_shape  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mto_pkg::CFG_STEP:   r_step   <= i_cfg_data[mto_pkg::PHASE_BITS-1:0];
                mto_pkg::CFG_OFFSET: r_offset <= i_cfg_data[mto_pkg::PHASE_BITS-1:0];
                mto_pkg::CFG_SHAPE:  r_shape  <= i_cfg_data[mto_pkg::SHAPE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (o_push) begin
                r_pend <= 1'b0;
            end
            if (w_accept) begin
                case (i_req_type)
                    mto_pkg::REQ_TICK: begin
                        r_phase <= r_phase + r_step;
                        r_pend  <= 1'b1;
                    end
                    mto_pkg::REQ_RESTART: r_phase <= r_offset;
                    mto_pkg::REQ_LOAD:    r_phase <= i_new_phase;
                    default: ;
                endcase
            end
        end
    end

    assign w_sampled = r_phase + r_offset;
    assign w_p = {1'b0, w_sampled[mto_pkg::PHASE_BITS-1 -: mto_pkg::FRAC_BITS]};
    assign w_s = (r_shape > mto_pkg::SHAPE_ONE) ? mto_pkg::SHAPE_ONE : r_shape;

    // falling part, rising part, or flat zero for a plain saw at phase zero
    always_comb begin
        if (w_p > w_s) begin
            o_job.num = mto_pkg::SHAPE_ONE - w_p;
            o_job.den = mto_pkg::SHAPE_ONE - w_s;
        end else if (w_s == '0) begin
            o_job.num = '0;
            o_job.den = mto_pkg::SHAPE_W'(1);
        end else begin
            o_job.num = w_p;
            o_job.den = w_s;
        end
    end

endmodule

// ----- rtl/mto_fifo.sv -----
// two-entry job queue between front end and divider
module mto_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mto_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output mto_pkg::t_job o_job,
    output logic          o_empty
);

    mto_pkg::t_job                  r_mem [mto_pkg::FIFO_DEPTH];
    logic [mto_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [mto_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [mto_pkg::FIFO_CNT_W-1:0] r_count;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_count == mto_pkg::FIFO_CNT_W'(mto_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/mto_back.sv -----
// back end: bit-serial divider, sample mapping and output register
module mto_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  mto_pkg::t_job                    i_job,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [mto_pkg::OUT_BITS-1:0] o_sample
);

    mto_pkg::t_back_state r_state;
    mto_pkg::t_back_state n_state;

    logic [mto_pkg::SHAPE_W-1:0]  r_rem;
    logic [mto_pkg::SHAPE_W-1:0]  r_den;
    logic [mto_pkg::SHAPE_W-1:0]  r_quo;
    logic [mto_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_out_valid;
    logic [mto_pkg::OUT_BITS-1:0] r_sample;

    logic                         w_last;
    logic                         w_load;
    logic [mto_pkg::SHAPE_W:0]    w_trial;
    logic                         w_ge;
    logic [mto_pkg::OUT_BITS-1:0] w_sat;

    assign w_last = (r_cnt == mto_pkg::CNT_W'(mto_pkg::DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            mto_pkg::ST_IDLE: if (!i_empty) n_state = mto_pkg::ST_DIV;
            mto_pkg::ST_DIV:  if (w_last) n_state = mto_pkg::ST_DONE;
            mto_pkg::ST_DONE: if (!r_out_valid || i_out_ready) n_state = mto_pkg::ST_IDLE;
            default:          n_state = mto_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        case (r_state)
            mto_pkg::ST_IDLE: o_pop  = !i_empty;
            mto_pkg::ST_DONE: w_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // first step tests the integer bit, later steps shift in a zero
    assign w_trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // u - half, u == 1.0 saturates
    assign w_sat = r_quo[mto_pkg::OUT_BITS] ? mto_pkg::SAMPLE_MAX
                 : {~r_quo[mto_pkg::OUT_BITS-1], r_quo[mto_pkg::OUT_BITS-2:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mto_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem <= i_job.num;
            r_den <= i_job.den;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_state == mto_pkg::ST_DIV) begin
            if (w_ge) begin
                r_rem <= mto_pkg::SHAPE_W'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= w_trial[mto_pkg::SHAPE_W-1:0];
            end
            r_quo <= {r_quo[mto_pkg::SHAPE_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_load) begin
            r_sample <= w_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule

// ----- rtl/morphing_trisaw_oscillator_core.sv -----
// top level of the morphing triangle/saw oscillator
//
// channels: request items (req_type, new_phase) in, sample items out,
// plus a register write port (0 phase step, 1 phase offset, 2 shape).
// a tick item advances the phase and yields one Q1.15 sample; restart
// and load items only set the phase and yield nothing.
// the front end takes a request and updates the phase register, then from
// the registered phase selects the rising or falling segment and queues a
// divide job. the back end runs a 17-step bit-serial divider and takes a
// new job from the queue only once the last sample is in the output
// register, so further jobs wait in the queue meanwhile.
// request ready drops for one cycle after each tick and stays low while
// the two-entry job queue is full.
// a stalled receiver holds the sample in the output register; the divider
// finishes its next job and waits, and the queue then fills up.
// synchronous reset clears the phase, the config registers and the queue;
// request ready is high in the first cycle after reset.
// register writes are taken every cycle and belong in idle periods.
module morphing_trisaw_oscillator_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [mto_pkg::REQ_W-1:0]             i_req_type,
    input  logic [mto_pkg::PHASE_BITS-1:0]        i_new_phase,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mto_pkg::OUT_BITS-1:0]   o_sample,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mto_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mto_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    mto_pkg::t_job w_push_job;
    mto_pkg::t_job w_pop_job;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;

    assign o_cfg_ready = 1'b1;

    mto_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_new_phase (i_new_phase),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_job       (w_push_job),
        .i_full      (w_full)
    );

    mto_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    mto_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample    (o_sample)
    );

endmodule

// ----- rtl/mto_checker.sv -----
// port-level checks for the oscillator core, bound to the top level
module mto_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [mto_pkg::OUT_BITS-1:0] o_sample,
    input logic                               o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("sample dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_sample))
        else $error("sample changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("core not empty and ready after reset");

    a_cfg_ready: assert property (@(posedge i_clk)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("register port not ready");

endmodule

bind morphing_trisaw_oscillator_core mto_checker u_mto_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_sample    (o_sample),
    .o_cfg_ready (o_cfg_ready)
);

// ----- dv/tb_morphing_trisaw_oscillator_core.sv -----
// testbench of the morphing triangle/saw oscillator core: phase prediction, sample checks
module tb_morphing_trisaw_oscillator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mto_pkg::REQ_W-1:0]     REQ_UNUSED = 2'd3;
    localparam logic [mto_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 150;

    typedef struct packed {
        logic [mto_pkg::REQ_W-1:0]      req;
        logic [mto_pkg::PHASE_BITS-1:0] phase;
    } t_osc_req;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                o_in_ready;
    logic [mto_pkg::REQ_W-1:0]           req_type = '0;
    logic [mto_pkg::PHASE_BITS-1:0]      new_phase = '0;
    logic                                o_out_valid;
    logic                                out_ready = 1'b0;
    logic signed [mto_pkg::OUT_BITS-1:0] o_sample;
    logic                                cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [mto_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [mto_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    // software copy of the oscillator
    logic [mto_pkg::PHASE_BITS-1:0]      step_reg = '0;
    logic [mto_pkg::PHASE_BITS-1:0]      offset_reg = '0;
    logic [mto_pkg::SHAPE_W-1:0]         shape_reg = '0;
    logic [mto_pkg::PHASE_BITS-1:0]      phase_acc = '0;

    t_osc_req                            req_q[$];
    logic signed [mto_pkg::OUT_BITS-1:0] sample_q[$];
    int                                  n_queued = 0;
    int                                  n_accepted = 0;
    int                                  errors = 0;

    int                                  burst_left = 0;
    int                                  gap_left = 0;
    int                                  stall_mode = 0;
    int                                  stall_left = 0;
    t_osc_req                            nxt;
    logic signed [mto_pkg::OUT_BITS-1:0] want;

    morphing_trisaw_oscillator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (req_type),
        .i_new_phase (new_phase),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_sample    (o_sample),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [mto_pkg::OUT_BITS-1:0] shape_sample(
        logic [mto_pkg::PHASE_BITS-1:0] ph, logic [mto_pkg::SHAPE_W-1:0] s_raw);
        logic [mto_pkg::SHAPE_W-1:0] s;
        logic [63:0]                 p;
        logic [63:0]                 u;
        int                          val;
        s = (s_raw > mto_pkg::SHAPE_ONE) ? mto_pkg::SHAPE_ONE : s_raw;
        p = 64'(ph[mto_pkg::PHASE_BITS-1 -: mto_pkg::FRAC_BITS]);
        if (p > 64'(s)) begin
            u = ((64'(mto_pkg::SHAPE_ONE) - p) << mto_pkg::OUT_BITS)
                / (64'(mto_pkg::SHAPE_ONE) - 64'(s));
        end else if (s == '0) begin
            u = '0;
        end else begin
            u = (p << mto_pkg::OUT_BITS) / 64'(s);
        end
        val = int'(u) - (1 << (mto_pkg::OUT_BITS - 1));
        if (val > int'(mto_pkg::SAMPLE_MAX)) val = int'(mto_pkg::SAMPLE_MAX);
        return val[mto_pkg::OUT_BITS-1:0];
    endfunction

    task automatic osc_advance(t_osc_req r);
        case (r.req)
            mto_pkg::REQ_TICK: begin
                phase_acc = phase_acc + step_reg;
                sample_q.push_back(shape_sample(phase_acc + offset_reg, shape_reg));
            end
            mto_pkg::REQ_RESTART: phase_acc = offset_reg;
            mto_pkg::REQ_LOAD:    phase_acc = r.phase;
            default: ;
        endcase
    endtask

    // request driver, bursts with gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                osc_advance('{req: req_type, phase: new_phase});
                n_accepted++;
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    nxt = req_q.pop_front();
                    in_valid  <= 1'b1;
                    req_type  <= nxt.req;
                    new_phase <= nxt.phase;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // sample monitor with its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (sample_q.size() == 0) begin
                    $error("sample item with none expected: actual %0d", o_sample);
                    errors++;
                end else begin
                    want = sample_q.pop_front();
                    if (o_sample !== want) begin
                        $error("sample mismatch: expected %0d, actual %0d", want, o_sample);
                        errors++;
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(16, 200);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic cfg_write(logic [mto_pkg::CFG_IDX_W-1:0] idx,
                             logic [mto_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mto_pkg::CFG_STEP:   step_reg   = data;
            mto_pkg::CFG_OFFSET: offset_reg = data;
            mto_pkg::CFG_SHAPE:  shape_reg  = data[mto_pkg::SHAPE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_req(logic [mto_pkg::REQ_W-1:0] r, logic [mto_pkg::PHASE_BITS-1:0] ph);
        req_q.push_back('{req: r, phase: ph});
        n_queued++;
    endtask

    task automatic wait_idle();
        int n;
        while (n_accepted != n_queued) @(posedge i_clk);
        n = 0;
        while (sample_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [mto_pkg::CFG_DATA_W-1:0] d;
        case ($urandom_range(0, 4))
            0:       d = '0;
            1:       d = '1;
            2:       d = $urandom_range(1, 32'h00ff_ffff);
            default: d = $urandom;
        endcase
        cfg_write(mto_pkg::CFG_STEP, d);
        case ($urandom_range(0, 3))
            0:       d = '0;
            1:       d = '1;
            default: d = $urandom;
        endcase
        cfg_write(mto_pkg::CFG_OFFSET, d);
        case ($urandom_range(0, 4))
            0:       d = '0;
            1:       d = 32'(mto_pkg::SHAPE_ONE);
            2:       d = 32'(mto_pkg::SHAPE_ONE >> 1);
            3:       d = $urandom_range(0, 32'(mto_pkg::SHAPE_ONE));
            default: d = $urandom_range(0, 32'h1_ffff);
        endcase
        if ($urandom_range(0, 1)) d = d | ($urandom << mto_pkg::SHAPE_W);
        cfg_write(mto_pkg::CFG_SHAPE, d);
        if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED, $urandom);
    endtask

    task automatic random_items(int count);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 68)      push_req(mto_pkg::REQ_TICK, $urandom);
            else if (k < 76) push_req(mto_pkg::REQ_RESTART, $urandom);
            else if (k < 94) push_req(mto_pkg::REQ_LOAD, $urandom);
            else             push_req(REQ_UNUSED, $urandom);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: saw, phase zero gives the most negative sample
        push_req(mto_pkg::REQ_TICK, '0);
        push_req(REQ_UNUSED, 32'hffff_ffff);
        push_req(mto_pkg::REQ_LOAD, 32'hffff_ffff);
        push_req(mto_pkg::REQ_TICK, '0);
        push_req(mto_pkg::REQ_RESTART, 32'h1234_5678);
        push_req(mto_pkg::REQ_TICK, 32'hffff_ffff);
        wait_idle();

        // shape beyond one acts as a ramp
        cfg_write(mto_pkg::CFG_STEP, '0);
        cfg_write(mto_pkg::CFG_OFFSET, 32'h8000_0000);
        cfg_write(mto_pkg::CFG_SHAPE, 32'hffff_ffff);
        push_req(mto_pkg::REQ_LOAD, '0);
        push_req(mto_pkg::REQ_TICK, '0);
        push_req(mto_pkg::REQ_LOAD, 32'h8000_0000);
        push_req(mto_pkg::REQ_TICK, '0);
        push_req(mto_pkg::REQ_LOAD, 32'h7fff_ffff);
        push_req(mto_pkg::REQ_TICK, '0);
        push_req(mto_pkg::REQ_RESTART, '0);
        push_req(mto_pkg::REQ_TICK, '0);
        push_req(REQ_UNUSED, 32'h5a5a_a5a5);
        push_req(mto_pkg::REQ_TICK, '0);
        wait_idle();

        // triangle with full step, peak saturates
        cfg_write(mto_pkg::CFG_STEP, '1);
        cfg_write(mto_pkg::CFG_OFFSET, '0);
        cfg_write(mto_pkg::CFG_SHAPE, 32'(mto_pkg::SHAPE_ONE >> 1));
        cfg_write(CFG_UNUSED, '1);
        push_req(mto_pkg::REQ_LOAD, 32'h8000_0000);
        push_req(mto_pkg::REQ_TICK, '0);
        push_req(mto_pkg::REQ_LOAD, 32'h8000_0001);
        push_req(mto_pkg::REQ_TICK, '0);
        push_req(mto_pkg::REQ_LOAD, '0);
        push_req(mto_pkg::REQ_TICK, '0);
        push_req(mto_pkg::REQ_TICK, '1);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_config();
            random_items(PHASE_ITEMS);
            wait_idle();
        end

        if (sample_q.size() != 0) begin
            $error("%0d expected sample items never arrived", sample_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
